### hdl/sbc_pkg.sv
// shared definitions for the sha-256 block compression engine
// opcodes, controller-to-datapath command struct and the round constant table
// no dependencies
package sbc_pkg;

  localparam logic [1:0] OpLoad   = 2'd0;
  localparam logic [1:0] OpAbsorb = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumVars = 8;
  localparam int unsigned NumSched = 16;
  localparam int unsigned NumRounds = 64;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic       load_en;
    logic [2:0] load_idx;
    logic       absorb_en;
    logic       start;
    logic       round_en;
    logic [5:0] round_idx;
    logic       final_en;
    logic       rd_load;
    logic [2:0] rd_idx;
  } sbc_cmd_t;

  function automatic word_t round_const(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

### hdl/sbc_ctrl.sv
// controller for the sha-256 block compression engine
// sequences absorb, the 64 rounds, the final add and the eight-word readout
// depends on sbc_pkg
module sbc_ctrl import sbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [2:0] state_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output sbc_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRound,
    StFinal,
    StRead
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] word_cnt_q, word_cnt_d;
  logic [5:0] round_q, round_d;
  logic [2:0] rd_q, rd_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_en   = accept && (op_i == OpLoad);
    cmd_o.load_idx  = state_index_i;
    cmd_o.absorb_en = accept && (op_i == OpAbsorb);
    cmd_o.start     = cmd_o.absorb_en && (word_cnt_q == 4'd15);
    cmd_o.round_en  = (state_q == StRound);
    cmd_o.round_idx = round_q;
    cmd_o.final_en  = (state_q == StFinal);
    cmd_o.rd_load   = (state_q == StRead) && (!out_valid_q || out_ready_i);
    cmd_o.rd_idx    = rd_q;
  end

  always_comb begin
    state_d     = state_q;
    word_cnt_d  = word_cnt_q;
    round_d     = round_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (cmd_o.absorb_en) begin
          word_cnt_d = word_cnt_q + 4'd1;
          if (cmd_o.start) begin
            state_d = StRound;
            round_d = '0;
          end
        end else if (accept && (op_i == OpRead)) begin
          state_d = StRead;
          rd_d    = '0;
        end
      end
      StRound: begin
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        state_d = StIdle;
      end
      StRead: begin
        if (cmd_o.rd_load) begin
          out_valid_d = 1'b1;
          rd_d        = rd_q + 3'd1;
          if (rd_q == 3'd7) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      word_cnt_q  <= '0;
      round_q     <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_cnt_q  <= word_cnt_d;
      round_q     <= round_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hdl/sbc_datapath.sv
// datapath for the sha-256 block compression engine
// chaining words, rolling 16-word schedule window, working variables, output register
// depends on sbc_pkg
module sbc_datapath import sbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sbc_cmd_t   cmd_i,
  input  word_t      data_word_i,
  output logic [2:0] digest_index_o,
  output word_t      digest_word_o,
  output logic       last_word_o
);

  word_t      chain_q [NumVars];
  word_t      win_q   [NumSched];
  word_t      var_q   [NumVars];
  word_t      sched_new;
  word_t      t1, t2;
  logic [2:0] dig_idx_q;
  word_t      dig_word_q;
  logic       last_q;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  assign sched_new = sig1(win_q[14]) + win_q[9] + sig0(win_q[1]) + win_q[0];

  assign t1 = var_q[7] + bsig1(var_q[4]) + (var_q[6] ^ (var_q[4] & (var_q[5] ^ var_q[6])))
            + round_const(cmd_i.round_idx) + win_q[0];
  assign t2 = bsig0(var_q[0])
            + ((var_q[0] & var_q[1]) | ((var_q[0] | var_q[1]) & var_q[2]));

  // chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumVars; i++) begin
        chain_q[i] <= '0;
      end
    end else if (cmd_i.load_en) begin
      chain_q[cmd_i.load_idx] <= data_word_i;
    end else if (cmd_i.final_en) begin
      for (int i = 0; i < NumVars; i++) begin
        chain_q[i] <= chain_q[i] + var_q[i];
      end
    end
  end

  // schedule window: oldest word at the bottom
  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb_en || cmd_i.round_en) begin
      for (int i = 0; i < NumSched - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[NumSched-1] <= cmd_i.absorb_en ? data_word_i : sched_new;
    end
  end

  // working variables a to h
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int i = 0; i < NumVars; i++) begin
        var_q[i] <= chain_q[i];
      end
    end else if (cmd_i.round_en) begin
      var_q[0] <= t1 + t2;
      var_q[1] <= var_q[0];
      var_q[2] <= var_q[1];
      var_q[3] <= var_q[2];
      var_q[4] <= var_q[3] + t1;
      var_q[5] <= var_q[4];
      var_q[6] <= var_q[5];
      var_q[7] <= var_q[6];
    end
  end

  // readout register
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_load) begin
      dig_idx_q  <= cmd_i.rd_idx;
      dig_word_q <= chain_q[cmd_i.rd_idx];
      last_q     <= (cmd_i.rd_idx == 3'd7);
    end
  end

  assign digest_index_o = dig_idx_q;
  assign digest_word_o  = dig_word_q;
  assign last_word_o    = last_q;

endmodule

### hdl/sha256_block_compress.sv
// top level of the sha-256 block compression engine
// joins the controller (sbc_ctrl) and the datapath (sbc_datapath); depends on sbc_pkg
//
//   channel  handshake               payload
//   in       in_valid_i/in_ready_o   op_i, state_index_i, data_word_i
//   out      out_valid_o/out_ready_i digest_index_o, digest_word_o, last_word_o
//
// load and absorb items are taken while idle; the sixteenth absorb of a block starts
// the 64 rounds through one shared round unit, then one final add
// a readout item emits eight items, one per cycle while the output is taken
// reset clears the chaining words and the word counter; the message buffer is not cleared
// a stalled output holds one item in the output register; in_ready_o is low
// while rounds run or a readout is being emitted
module sha256_block_compress import sbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [2:0]  state_index_i,
  input  logic [31:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  digest_index_o,
  output logic [31:0] digest_word_o,
  output logic        last_word_o
);

  sbc_cmd_t cmd;

  sbc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .state_index_i (state_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cmd_o         (cmd)
  );

  sbc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .data_word_i    (data_word_i),
    .digest_index_o (digest_index_o),
    .digest_word_o  (digest_word_o),
    .last_word_o    (last_word_o)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for sha256_block_compress: directed and random load, absorb and
// readout items against an in-bench sha-256 chaining model, with bursty input and output stalls
// depends on sbc_pkg and the rtl of sha256_block_compress
module tb_top;
  import sbc_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int IdleLimit = 2000;
  localparam int RandomItems = 210;
  localparam int TailCycles = 150;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] sel;
    word_t      data;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0] idx;
    word_t      word;
    logic       last_flag;
  } digest_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [2:0]  state_index_i = '0;
  logic [31:0] data_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  digest_index_o;
  logic [31:0] digest_word_o;
  logic        last_word_o;

  cmd_item_t    cmd_q [$];
  digest_item_t digest_q [$];
  cmd_item_t    next_cmd;
  digest_item_t want;

  word_t      chain_words [8] = '{default: '0};
  word_t      msg_words [16] = '{default: '0};
  logic [3:0] msg_count = '0;

  int burst_left = 0;
  int gap_left = 0;
  int rx_tick = 0;
  int err_count = 0;
  int idle_cycles = 0;

  sha256_block_compress dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .state_index_i  (state_index_i),
    .data_word_i    (data_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_index_o (digest_index_o),
    .digest_word_o  (digest_word_o),
    .last_word_o    (last_word_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_into_chain();
    word_t w [64];
    word_t v [8];
    word_t s0, s1, t1, t2;
    for (int k = 0; k < 16; k++) w[k] = msg_words[k];
    for (int k = 16; k < 64; k++) begin
      s1 = rotr(w[k-2], 17) ^ rotr(w[k-2], 19) ^ (w[k-2] >> 10);
      s0 = rotr(w[k-15], 7) ^ rotr(w[k-15], 18) ^ (w[k-15] >> 3);
      w[k] = s1 + w[k-7] + s0 + w[k-16];
    end
    v = chain_words;
    for (int k = 0; k < 64; k++) begin
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[k] + w[k];
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) chain_words[k] = chain_words[k] + v[k];
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(logic [1:0] op, logic [2:0] sel, word_t data);
    cmd_q.push_back('{op: op, sel: sel, data: data});
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || in_valid_i || digest_q.size() != 0) @(posedge clk_i);
  endtask

  // driver and chaining model, updated on each accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        case (op_i)
          OpLoad: chain_words[state_index_i] = data_word_i;
          OpAbsorb: begin
            msg_words[msg_count] = data_word_i;
            msg_count = msg_count + 4'd1;
            if (msg_count == '0) compress_into_chain();
          end
          OpRead: begin
            for (int k = 0; k < 8; k++)
              digest_q.push_back('{idx: 3'(k), word: chain_words[k], last_flag: (k == 7)});
          end
          default: ;
        endcase
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        next_cmd = cmd_q.pop_front();
        in_valid_i <= 1'b1;
        op_i <= next_cmd.op;
        state_index_i <= next_cmd.sel;
        data_word_i <= next_cmd.data;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor and output stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $error("unexpected item: digest_index %0d digest_word %h last_word %0b",
                 digest_index_o, digest_word_o, last_word_o);
          err_count++;
        end else begin
          want = digest_q.pop_front();
          if (digest_index_o !== want.idx) begin
            $error("digest_index: expected %0d, got %0d", want.idx, digest_index_o);
            err_count++;
          end
          if (digest_word_o !== want.word) begin
            $error("digest_word: expected %h, got %h", want.word, digest_word_o);
            err_count++;
          end
          if (last_word_o !== want.last_flag) begin
            $error("last_word: expected %0b, got %0b", want.last_flag, last_word_o);
            err_count++;
          end
        end
      end
      rx_tick++;
      if ((rx_tick / 97) % 3 == 0) begin
        out_ready_i <= 1'b1;
      end else if ((rx_tick / 97) % 3 == 1) begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready_i <= ((rx_tick % 5) < 2);
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int  issued;
    int  pick;
    bit  paused;
    issued = 0;
    paused = 1'b0;

    // readout of the reset state, with ignored fields set
    queue_cmd(OpRead, 3'd5, '1);
    queue_cmd(OpUnused, 3'd7, '1);
    queue_cmd(OpLoad, 3'd0, '1);
    queue_cmd(OpLoad, 3'd7, 32'h8000_0001);
    queue_cmd(OpAbsorb, 3'd7, '1);
    queue_cmd(OpAbsorb, 3'd0, '0);
    // partial block stays pending across a readout
    queue_cmd(OpRead, 3'd0, '0);
    for (int k = 0; k < 6; k++) queue_cmd(OpAbsorb, 3'($urandom), $urandom);
    // load while a block is pending
    queue_cmd(OpLoad, 3'd3, $urandom);
    for (int k = 0; k < 7; k++) queue_cmd(OpAbsorb, 3'($urandom), $urandom);
    queue_cmd(OpAbsorb, 3'd0, 32'h8000_0000);
    queue_cmd(OpRead, 3'd2, $urandom);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    while (issued < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        for (int k = 0; k < 8; k++) queue_cmd(OpLoad, 3'(k), rand_word());
        issued += 8;
      end else if (pick < 17) begin
        queue_cmd(OpRead, 3'($urandom), $urandom);
        issued++;
      end else if (pick < 22) begin
        queue_cmd(OpUnused, 3'($urandom), $urandom);
      end else if (pick < 30) begin
        queue_cmd(OpLoad, 3'($urandom), rand_word());
        issued++;
      end else begin
        queue_cmd(OpAbsorb, 3'($urandom), rand_word());
        issued++;
      end
      if (!paused && issued >= RandomItems / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
